### sv/jssc_pkg.sv
package jssc_pkg;

  localparam int HEADER_SKIP_DEFAULT = 10;
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [15:0] SOS_MARKER = 16'hFFDA;
  localparam logic [7:0]  BYTE_FF    = 8'hFF;
  localparam logic [7:0]  BYTE_EOI   = 8'hD9;
  localparam logic [7:0]  BYTE_ZERO  = 8'h00;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

  localparam logic        DIRECTION_RESET = 1'b0;
  localparam logic [15:0] MARKER_RESET    = 16'hFFDA;
  localparam logic [15:0] LENGTH_RESET    = 16'd2;
  localparam logic [15:0] SLICE_RESET     = 16'd0;

  localparam int REG_INDEX_W = 2;
  localparam logic [REG_INDEX_W-1:0] REG_DIRECTION = 2'd0;
  localparam logic [REG_INDEX_W-1:0] REG_MARKER    = 2'd1;
  localparam logic [REG_INDEX_W-1:0] REG_LENGTH    = 2'd2;
  localparam logic [REG_INDEX_W-1:0] REG_SLICE     = 2'd3;

  localparam logic DIR_WRITE  = 1'b0;
  localparam logic DIR_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_SHORT  = 2'd1;
  localparam logic [1:0] STATUS_LENGTH = 2'd2;

  localparam int SLOT_COUNT = 8;
  localparam logic [SLOT_COUNT-1:0] SLOT_HDR0  = 8'b0000_0001;
  localparam logic [SLOT_COUNT-1:0] SLOT_HDR1  = 8'b0000_0010;
  localparam logic [SLOT_COUNT-1:0] SLOT_HDR2  = 8'b0000_0100;
  localparam logic [SLOT_COUNT-1:0] SLOT_HDR3  = 8'b0000_1000;
  localparam logic [SLOT_COUNT-1:0] SLOT_DATA  = 8'b0001_0000;
  localparam logic [SLOT_COUNT-1:0] SLOT_STUFF = 8'b0010_0000;
  localparam logic [SLOT_COUNT-1:0] SLOT_EOI0  = 8'b0100_0000;
  localparam logic [SLOT_COUNT-1:0] SLOT_EOI1  = 8'b1000_0000;

  typedef struct packed {
    logic [SLOT_COUNT-1:0] slots;
    logic                  data_vld;
    logic [7:0]            data;
    logic [15:0]           marker;
    logic [15:0]           word;
    logic                  last;
    logic [15:0]           stuff_count;
    logic [1:0]            status;
  } cmd_t;

endpackage

### sv/jssc_in_if.sv
interface jssc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

### sv/jssc_out_if.sv
interface jssc_out_if;
  logic        valid;
  logic        ready;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_last;
  logic [15:0] stuff_count;
  logic [1:0]  status;

  modport source (output valid, output out_valid, output out_byte, output out_last,
                  output stuff_count, output status, input ready);
  modport sink (input valid, input out_valid, input out_byte, input out_last,
                input stuff_count, input status, output ready);
endinterface

### sv/jssc_cfg_if.sv
interface jssc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### sv/jpeg_segment_stuffing_codec.sv
// JPEG segment codec with marker byte stuffing.
// ingress: one data byte of a segment per transaction, last_byte on the final one.
// egress: one stream byte per transaction; out_valid low marks a bare end mark,
//   out_last flags the final result of a segment with stuff_count and status.
// cfg: register writes (0 direction, 1 marker_code, 2 segment_length,
//   3 slice_word); always ready, write only while the block is idle.
// Write mode opens a segment with marker and length (or slice) word, stuffs
// 0x00 after 0xFF past the header in start-of-scan and appends FF D9.
// Remove mode drops stuff bytes and checks the byte count against the length.
// The front classifies a byte in its accept cycle and queues at most one
// command, none for a dropped stuff byte that is not last; the back emits one
// result per cycle from the command while egress is ready, 1 to 7 per command.
// Ingress stays ready until the command queue fills.
// Reset clears segment state, the queue and the output valid flag, and loads
// register defaults. When egress stalls the output register holds and the
// queue absorbs up to QUEUE_DEPTH commands before ingress ready drops.
module jpeg_segment_stuffing_codec
  import jssc_pkg::*;
#(
  parameter int HEADER_SKIP = HEADER_SKIP_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  jssc_cfg_if.sink   cfg,
  jssc_in_if.sink    ingress,
  jssc_out_if.source egress
);

  logic push;
  cmd_t push_cmd;
  logic full;
  logic pop;
  logic nonempty;
  cmd_t head;

  jssc_front #(
    .HEADER_SKIP(HEADER_SKIP)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .ingress (ingress),
    .full    (full),
    .push    (push),
    .cmd     (push_cmd)
  );

  jssc_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .nonempty (nonempty),
    .head     (head)
  );

  jssc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .nonempty (nonempty),
    .head     (head),
    .pop      (pop),
    .egress   (egress)
  );

endmodule

### sv/jssc_front.sv
module jssc_front
  import jssc_pkg::*;
#(
  parameter int HEADER_SKIP = HEADER_SKIP_DEFAULT
) (
  input  logic   clk,
  input  logic   rst,
  jssc_cfg_if.sink cfg,
  jssc_in_if.sink  ingress,
  input  logic   full,
  output logic   push,
  output cmd_t   cmd
);

  localparam logic [15:0] SKIP = 16'(HEADER_SKIP);

  logic        direction;
  logic [15:0] marker_code;
  logic [15:0] segment_length;
  logic [15:0] slice_word;

  logic [15:0] byte_count;
  logic        prev_was_ff;
  logic [15:0] stuffed_total;
  logic        header_sent;

  logic [15:0] byte_count_next;
  logic        prev_was_ff_next;
  logic [15:0] stuffed_total_next;
  logic        header_sent_next;

  logic        accept;
  logic        sos;
  logic        is_ff;
  logic        at_body;
  logic        do_stuff;
  logic        do_drop;
  logic        do_eoi;
  logic        do_hdr;
  logic [1:0]  status;

  assign cfg.ready     = 1'b1;
  assign ingress.ready = !full;
  assign accept        = ingress.valid && !full;

  assign sos     = (marker_code == SOS_MARKER);
  assign is_ff   = (ingress.data_byte == BYTE_FF);
  assign at_body = (byte_count >= SKIP);

  always_comb begin
    byte_count_next    = (byte_count == COUNT_MAX) ? byte_count : byte_count + 16'd1;
    prev_was_ff_next   = prev_was_ff;
    stuffed_total_next = stuffed_total;
    header_sent_next   = header_sent;
    do_stuff           = 1'b0;
    do_drop            = 1'b0;
    do_eoi             = 1'b0;
    do_hdr             = 1'b0;
    status             = STATUS_OK;
    if (direction == DIR_WRITE) begin
      do_hdr           = !header_sent;
      header_sent_next = 1'b1;
      do_stuff         = sos && is_ff && at_body && (byte_count != 16'd0);
      do_eoi           = ingress.last_byte && sos;
      if (do_stuff && stuffed_total != COUNT_MAX) begin
        stuffed_total_next = stuffed_total + 16'd1;
      end
      if (do_eoi && byte_count_next < SKIP) begin
        status = STATUS_SHORT;
      end
    end else begin
      do_drop = prev_was_ff && (ingress.data_byte == BYTE_ZERO);
      if (do_drop) begin
        prev_was_ff_next = 1'b0;
        if (stuffed_total != COUNT_MAX) begin
          stuffed_total_next = stuffed_total + 16'd1;
        end
      end else begin
        prev_was_ff_next = is_ff && at_body;
      end
      if (segment_length < 16'd2 || byte_count_next != segment_length - 16'd2) begin
        status = STATUS_LENGTH;
      end else if (byte_count_next < SKIP) begin
        status = STATUS_SHORT;
      end
    end
  end

  always_comb begin
    cmd.slots = SLOT_DATA;
    if (do_hdr) begin
      cmd.slots = cmd.slots | SLOT_HDR0 | SLOT_HDR1 | SLOT_HDR2 | SLOT_HDR3;
    end
    if (do_stuff) begin
      cmd.slots = cmd.slots | SLOT_STUFF;
    end
    if (do_eoi) begin
      cmd.slots = cmd.slots | SLOT_EOI0 | SLOT_EOI1;
    end
    cmd.data_vld    = !do_drop;
    cmd.data        = do_drop ? BYTE_ZERO : ingress.data_byte;
    cmd.marker      = marker_code;
    cmd.word        = sos ? slice_word : segment_length;
    cmd.last        = ingress.last_byte;
    cmd.stuff_count = ingress.last_byte ? stuffed_total_next : 16'd0;
    cmd.status      = ingress.last_byte ? status : STATUS_OK;
  end

  assign push = accept && (!do_drop || ingress.last_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      direction      <= DIRECTION_RESET;
      marker_code    <= MARKER_RESET;
      segment_length <= LENGTH_RESET;
      slice_word     <= SLICE_RESET;
      byte_count     <= 16'd0;
      prev_was_ff    <= 1'b0;
      stuffed_total  <= 16'd0;
      header_sent    <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_DIRECTION: direction      <= cfg.data[0];
          REG_MARKER:    marker_code    <= cfg.data;
          REG_LENGTH:    segment_length <= cfg.data;
          REG_SLICE:     slice_word     <= cfg.data;
          default: ;
        endcase
      end
      if (accept) begin
        if (ingress.last_byte) begin
          byte_count    <= 16'd0;
          prev_was_ff   <= 1'b0;
          stuffed_total <= 16'd0;
          header_sent   <= 1'b0;
        end else begin
          byte_count    <= byte_count_next;
          prev_was_ff   <= prev_was_ff_next;
          stuffed_total <= stuffed_total_next;
          header_sent   <= header_sent_next;
        end
      end
    end
  end

endmodule

### sv/jssc_queue.sv
module jssc_queue
  import jssc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output cmd_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full     = (count == FULL_COUNT);
  assign nonempty = (count != '0);
  assign head     = entries[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### sv/jssc_back.sv
module jssc_back
  import jssc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic nonempty,
  input  cmd_t head,
  output logic pop,
  jssc_out_if.source egress
);

  cmd_t                  cur;
  logic [SLOT_COUNT-1:0] slots;
  logic [SLOT_COUNT-1:0] slots_next;
  logic [SLOT_COUNT-1:0] lowest;
  logic [SLOT_COUNT-1:0] rest;
  logic                  advance;
  logic                  emit;
  logic                  o_valid;
  logic                  o_out_valid;
  logic [7:0]            o_byte;
  logic                  o_last;
  logic [15:0]           o_stuff;
  logic [1:0]            o_status;
  logic                  sel_valid;
  logic [7:0]            sel_byte;
  logic                  sel_last;

  assign advance = !o_valid || egress.ready;
  assign lowest  = slots & (~slots + SLOT_COUNT'(1));
  assign rest    = slots & ~lowest;

  always_comb begin
    sel_valid = 1'b1;
    case (lowest)
      SLOT_HDR0:  sel_byte = cur.marker[15:8];
      SLOT_HDR1:  sel_byte = cur.marker[7:0];
      SLOT_HDR2:  sel_byte = cur.word[15:8];
      SLOT_HDR3:  sel_byte = cur.word[7:0];
      SLOT_DATA: begin
        sel_byte  = cur.data;
        sel_valid = cur.data_vld;
      end
      SLOT_STUFF: sel_byte = BYTE_ZERO;
      SLOT_EOI0:  sel_byte = BYTE_FF;
      SLOT_EOI1:  sel_byte = BYTE_EOI;
      default:    sel_byte = BYTE_ZERO;
    endcase
    sel_last = cur.last && (rest == '0);
  end

  always_comb begin
    emit       = 1'b0;
    pop        = 1'b0;
    slots_next = slots;
    if (slots != '0) begin
      if (advance) begin
        emit       = 1'b1;
        slots_next = rest;
        pop        = (rest == '0) && nonempty;
      end
    end else begin
      pop = nonempty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (emit) begin
      o_out_valid <= sel_valid;
      o_byte      <= sel_byte;
      o_last      <= sel_last;
      o_stuff     <= sel_last ? cur.stuff_count : 16'd0;
      o_status    <= sel_last ? cur.status : STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots   <= '0;
      o_valid <= 1'b0;
    end else begin
      slots <= pop ? head.slots : slots_next;
      if (emit) begin
        o_valid <= 1'b1;
      end else if (egress.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  assign egress.valid       = o_valid;
  assign egress.out_valid   = o_out_valid;
  assign egress.out_byte    = o_byte;
  assign egress.out_last    = o_last;
  assign egress.stuff_count = o_stuff;
  assign egress.status      = o_status;

endmodule

### sv/jssc_checker.sv
module jssc_checker
  import jssc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        valid,
  input logic        ready,
  input logic        out_valid,
  input logic [7:0]  out_byte,
  input logic        out_last,
  input logic [15:0] stuff_count,
  input logic [1:0]  status
);

  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !valid)
    else $error("egress valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(out_byte) && $stable(out_last))
    else $error("egress transaction changed while stalled");

  a_summary_on_last: assert property (@(posedge clk) disable iff (rst)
    valid && !out_last |-> stuff_count == 16'd0 && status == STATUS_OK)
    else $error("summary fields set on a non-final result");

  a_bare_mark: assert property (@(posedge clk) disable iff (rst)
    valid && !out_valid |-> out_last && out_byte == BYTE_ZERO)
    else $error("bare end mark not final or not zero");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    valid |-> status == STATUS_OK || status == STATUS_SHORT || status == STATUS_LENGTH)
    else $error("undefined status code");

endmodule

bind jpeg_segment_stuffing_codec jssc_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .valid       (egress.valid),
  .ready       (egress.ready),
  .out_valid   (egress.out_valid),
  .out_byte    (egress.out_byte),
  .out_last    (egress.out_last),
  .stuff_count (egress.stuff_count),
  .status      (egress.status)
);
